FILE: rtl/core/c8x_pkg.sv
`timescale 1ns / 1ps
package c8x_pkg;

  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned AddrW      = 12;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  localparam logic [0:0] RegProgramStart = 1'd0;
  localparam logic [0:0] RegPaused       = 1'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] pc_after;
    logic [15:0] opcode;
    logic        clear_screen;
    logic        draw_valid;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [7:0]  draw_bits;
    logic        last;
  } out_item_t;

  // controller -> datapath commands
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_TICK,
    CMD_FETCH_HI,
    CMD_FETCH_LO,
    CMD_EXEC,
    CMD_DRAW_RD,
    CMD_DRAW_EMIT,
    CMD_STORE,
    CMD_LOAD_RD,
    CMD_LOAD_WR,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] cnt;
  } ctl_cmd_t;

  typedef struct packed {
    logic       is_draw;
    logic       is_store;
    logic       is_restore;
    logic [3:0] n;
    logic [3:0] x;
  } dp_stat_t;

endpackage

FILE: rtl/core/c8x_ctrl.sv
`timescale 1ns / 1ps
module c8x_ctrl
  import c8x_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0] in_op_i,
  input  logic     paused_i,
  input  dp_stat_t stat_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FHI   = 4'd1;
  localparam logic [3:0] S_FLO   = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;
  localparam logic [3:0] S_DEMIT = 4'd5;
  localparam logic [3:0] S_MEM   = 4'd6;
  localparam logic [3:0] S_MWR   = 4'd7;
  localparam logic [3:0] S_DEC   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_free;

  assign out_free   = !out_valid_i || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.cmd = CMD_IDLE;
    cmd_o.cnt = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.cmd = CMD_LOAD;
          end else if (in_op_i == OP_STEP && !paused_i) begin
            cmd_o.cmd = CMD_FETCH_HI;
            state_d   = S_FLO;
          end else if (in_op_i == OP_TICK) begin
            cmd_o.cmd = CMD_TICK;
          end else begin
            cmd_o.cmd = CMD_EMIT;
          end
        end
      end
      S_FHI: state_d = S_FLO;
      S_FLO: begin
        cmd_o.cmd = CMD_FETCH_LO;
        state_d   = S_DEC;
      end
      S_DEC: state_d = S_EXEC;
      S_EXEC: begin
        cnt_d = '0;
        if (stat_i.is_draw && stat_i.n != 4'd0) begin
          cmd_o.cmd = CMD_DRAW_RD;
          cmd_o.cnt = 4'd0;
          state_d   = S_DEMIT;
        end else if (stat_i.is_store) begin
          cmd_o.cmd = CMD_STORE;
          cmd_o.cnt = 4'd0;
          cnt_d     = 4'd1;
          state_d   = (stat_i.x == 4'd0) ? S_DEMIT : S_MEM;
        end else if (stat_i.is_restore) begin
          cmd_o.cmd = CMD_LOAD_RD;
          cmd_o.cnt = 4'd0;
          state_d   = S_MWR;
        end else if (out_free) begin
          cmd_o.cmd = CMD_EXEC;
          state_d   = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.cmd = CMD_DRAW_RD;
        state_d   = S_DEMIT;
      end
      S_DEMIT: begin
        if (stat_i.is_draw) begin
          if (out_free) begin
            cmd_o.cmd = CMD_DRAW_EMIT;
            if (cnt_q + 4'd1 == stat_i.n) begin
              state_d = S_IDLE;
            end else begin
              cnt_d   = cnt_q + 4'd1;
              state_d = S_DRD;
            end
          end else begin
            // keep the row byte in the read register
            cmd_o.cmd = CMD_DRAW_RD;
          end
        end else if (out_free) begin
          cmd_o.cmd = CMD_EXEC;
          state_d   = S_IDLE;
        end
      end
      S_MEM: begin
        cmd_o.cmd = CMD_STORE;
        cnt_d     = cnt_q + 4'd1;
        if (cnt_q == stat_i.x) state_d = S_DEMIT;
      end
      S_MWR: begin
        cmd_o.cmd = CMD_LOAD_WR;
        if (cnt_q == stat_i.x) begin
          state_d = S_DEMIT;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_FHI;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // S_FHI doubles as the read cycle between restore writes
    if (state_q == S_FHI && stat_i.is_restore) begin
      cmd_o.cmd = CMD_LOAD_RD;
      state_d   = S_MWR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("ready outside idle");
  a_draw_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEMIT && stat_i.is_draw) |-> cnt_q < stat_i.n)
    else $error("draw row count overrun");
  a_accept_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_op_i == OP_STEP && !paused_i) |=> state_q == S_FLO)
    else $error("step did not start fetch");
`endif

endmodule

FILE: rtl/core/c8x_dpath.sv
`timescale 1ns / 1ps
module c8x_dpath
  import c8x_pkg::*;
#(
  parameter int unsigned MEM_BYTES   = MemBytes,
  parameter int unsigned STACK_DEPTH = StackDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctl_cmd_t  cmd_i,
  input  in_item_t  item_i,
  input  logic      cfg_pc_we_i,
  input  logic [11:0] cfg_pc_i,
  input  logic      paused_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH);
  localparam int unsigned LvW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MaW = $clog2(MEM_BYTES);

  logic [7:0]  mem_q [MEM_BYTES];
  logic [11:0] stk_q [STACK_DEPTH];
  logic [7:0]  v_q [16];
  logic [11:0] pc_q, idx_q;
  logic [7:0]  dt_q, rdata_q, rnd_q;
  logic [15:0] opc_q;
  logic [LvW-1:0] lvl_q;
  logic        ov_q;
  out_item_t   out_q;

  logic        mem_we;
  logic [MaW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;
  logic [3:0]  x, y;
  logic [7:0]  vx, vy, kk;
  logic [11:0] idx_off;

  assign x  = opc_q[11:8];
  assign y  = opc_q[7:4];
  assign kk = opc_q[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign idx_off = idx_q + {8'd0, cmd_i.cnt};

  assign stat_o.is_draw    = opc_q[15:12] == 4'hD;
  assign stat_o.is_store   = opc_q[15:12] == 4'hF && kk == 8'h55;
  assign stat_o.is_restore = opc_q[15:12] == 4'hF && kk == 8'h65;
  assign stat_o.n          = opc_q[3:0];
  assign stat_o.x          = x;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = item_i.load_address[MaW-1:0];
    mem_wd = item_i.load_data;
    mem_ra = pc_q[MaW-1:0];
    case (cmd_i.cmd)
      CMD_LOAD: mem_we = 1'b1;
      CMD_FETCH_LO: mem_ra = MaW'(pc_q + 12'd1);
      CMD_STORE: begin
        mem_we = 1'b1;
        mem_wa = idx_off[MaW-1:0];
        mem_wd = v_q[cmd_i.cnt];
      end
      CMD_DRAW_RD, CMD_LOAD_RD: mem_ra = idx_off[MaW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  function automatic out_item_t plain(logic [11:0] pc, logic [1:0] st, logic [15:0] op,
                                      logic clr);
    out_item_t o;
    o = '0;
    o.status = st;
    o.pc_after = pc;
    o.opcode = op;
    o.clear_screen = clr;
    o.last = 1'b1;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [8:0]  sum;
    logic [11:0] pcn;
    logic [1:0]  st;
    logic        clr;
    logic        ovld;
    if (!rst_ni) begin
      pc_q        <= 12'h200;
      idx_q       <= '0;
      dt_q        <= '0;
      lvl_q       <= '0;
      out_valid_o <= 1'b0;
      opc_q       <= '0;
      ov_q        <= 1'b0;
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
    end else begin
      ovld = out_valid_o && !out_ready_i;
      if (cfg_pc_we_i) pc_q <= cfg_pc_i;
      case (cmd_i.cmd)
        CMD_LOAD, CMD_EMIT: begin
          out_q <= plain(pc_q, ST_OK, 16'd0, 1'b0);
          ovld = 1'b1;
        end
        CMD_TICK: begin
          if (!paused_i && dt_q != 8'd0) dt_q <= dt_q - 8'd1;
          out_q <= plain(pc_q, ST_OK, 16'd0, 1'b0);
          ovld = 1'b1;
        end
        CMD_FETCH_HI: rnd_q <= item_i.random_byte;
        CMD_FETCH_LO: opc_q[15:8] <= rdata_q;
        CMD_EXEC: begin
          pcn = pc_q + 12'd2;
          st  = ST_OK;
          clr = 1'b0;
          case (opc_q[15:12])
            4'h0: begin
              if (opc_q[11:0] == 12'h0E0) clr = 1'b1;
              else if (opc_q[11:0] == 12'h0EE) begin
                if (lvl_q == '0) st = ST_UNDERFLOW;
                else begin
                  lvl_q <= lvl_q - 1'b1;
                  pcn = stk_q[SpW'(lvl_q - 1'b1)];
                end
              end
            end
            4'h1: pcn = opc_q[11:0];
            4'h2: begin
              if (lvl_q >= LvW'(STACK_DEPTH)) st = ST_OVERFLOW;
              else begin
                stk_q[SpW'(lvl_q)] <= pcn;
                lvl_q <= lvl_q + 1'b1;
                pcn = opc_q[11:0];
              end
            end
            4'h3: if (vx == kk) pcn = pcn + 12'd2;
            4'h4: if (vx != kk) pcn = pcn + 12'd2;
            4'h5: if (vx == vy) pcn = pcn + 12'd2;
            4'h6: v_q[x] <= kk;
            4'h7: v_q[x] <= vx + kk;
            4'h8: begin
              case (opc_q[3:0])
                4'h0: v_q[x] <= vy;
                4'h1: v_q[x] <= vx | vy;
                4'h2: v_q[x] <= vx & vy;
                4'h3: v_q[x] <= vx ^ vy;
                4'h4: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  if (x != 4'hF) v_q[x] <= sum[7:0];
                  v_q[15] <= {7'd0, sum[8]};
                end
                4'h5: begin
                  if (x != 4'hF) v_q[x] <= vx - vy;
                  v_q[15] <= {7'd0, vx > vy};
                end
                4'h6: begin
                  if (x != 4'hF) v_q[x] <= vx >> 1;
                  v_q[15] <= {7'd0, vx[0]};
                end
                default: st = ST_UNKNOWN;
              endcase
            end
            4'h9: if (vx != vy) pcn = pcn + 12'd2;
            4'hA: idx_q <= opc_q[11:0];
            4'hB: pcn = opc_q[11:0] + {4'd0, v_q[0]};
            4'hC: v_q[x] <= rnd_q & kk;
            4'hD: v_q[15] <= '0;
            4'hF: begin
              case (kk)
                8'h07: v_q[x] <= dt_q;
                8'h15: dt_q <= vx;
                8'h1E: idx_q <= idx_q + {4'd0, vx};
                8'h29: idx_q <= {4'd0, vx} + {2'd0, vx, 2'd0};
                8'h55, 8'h65: ;
                default: st = ST_UNKNOWN;
              endcase
            end
            default: st = ST_UNKNOWN;
          endcase
          pc_q <= pcn;
          out_q <= plain(pcn, st, opc_q, clr);
          ovld = 1'b1;
        end
        CMD_DRAW_EMIT: begin
          out_q <= '{status: ST_OK, pc_after: pc_q + 12'd2, opcode: opc_q,
                     clear_screen: 1'b0, draw_valid: 1'b1, draw_x: vx,
                     draw_y: vy + {4'd0, cmd_i.cnt}, draw_bits: rdata_q,
                     last: (cmd_i.cnt + 4'd1 == opc_q[3:0])};
          ovld = 1'b1;
          if (cmd_i.cnt + 4'd1 == opc_q[3:0]) begin
            pc_q <= pc_q + 12'd2;
            v_q[15] <= '0;
          end
        end
        CMD_LOAD_WR: v_q[cmd_i.cnt] <= rdata_q;
        default: ;
      endcase
      out_valid_o <= ovld;
      // the fetch_lo read puts the low byte in rdata_q; ov_q then copies it into opc_q[7:0]
      if (cmd_i.cmd == CMD_FETCH_LO) ov_q <= 1'b1;
      else if (ov_q) begin
        ov_q        <= 1'b0;
        opc_q[7:0]  <= rdata_q;
      end
    end
  end

  assign out_o = out_q;

`ifndef ASSERT_OFF
  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvW'(STACK_DEPTH))
    else $error("stack level out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_q))
    else $error("result dropped under stall");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> cmd_i.cmd != CMD_EXEC && cmd_i.cmd != CMD_DRAW_EMIT)
    else $error("result overwritten");
`endif

endmodule

FILE: rtl/core/chip8_instruction_executor.sv
`timescale 1ns / 1ps
// CHIP-8 instruction executor.
// Input channel (in_valid_i/in_ready_o, in_item_i): one transaction is a
// memory load, an instruction step, a delay timer tick or an unused op.
// Output channel (out_valid_o/out_ready_i, out_item_o): one transaction per
// result; a draw with n rows gives n transactions, last marks the final one.
// The 4 KiB memory has one read and one write address; every fetch byte,
// row and register copy is one access.
// One item is worked at a time; the next one is taken at the earliest in the
// cycle its final result leaves, so loads can run one per cycle while the
// receiver takes each result.
// Configuration (APB, 4-byte registers): 0x0 program_start (also loads the
// PC), 0x4 paused. Write only while idle.
// Reset: PC = 0x200, registers, index, timer and stack level cleared;
// memory content is undefined until loaded.
// A stalled receiver holds the result register and the block stops taking
// input until the result is taken.
module chip8_instruction_executor
  import c8x_pkg::*;
#(
  parameter int unsigned MEM_BYTES   = MemBytes,
  parameter int unsigned STACK_DEPTH = StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] start_q;
  logic        paused_q;
  logic        wr;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 12'h200;
      paused_q <= 1'b0;
    end else if (wr && paddr[1:0] == 2'd0) begin
      if (paddr[2] == RegProgramStart) start_q <= pwdata[11:0];
      else paused_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegProgramStart) prdata = {20'd0, start_q};
    else prdata = {31'd0, paused_q};
  end

  c8x_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_op_i(in_item_i.op), .paused_i(paused_q), .stat_i(stat),
    .out_valid_i(out_valid_o), .out_ready_i, .cmd_o(cmd)
  );

  c8x_dpath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_item_i),
    .cfg_pc_we_i(wr && paddr == 3'd0), .cfg_pc_i(pwdata[11:0]),
    .paused_i(paused_q), .stat_o(stat), .out_valid_o, .out_ready_i,
    .out_o(out_item_o)
  );

endmodule
